FILE: hw/rtl/tlvob_pkg.sv
// Shared types and constants of the TLV option list builder and parser.
package tlvob_pkg;

  localparam int unsigned BUF_BYTES      = 256;
  localparam int unsigned MAX_OPTION_LEN = 64;
  localparam int unsigned QUEUE_DEPTH    = 2;

  localparam logic [7:0] SINGLE_LIMIT = 8'd32;
  localparam logic [7:0] FEAT_FIRST   = 8'd32;
  localparam logic [7:0] FEAT_LAST    = 8'd35;

  // operation codes
  localparam logic [2:0] OP_ADD   = 3'd0;
  localparam logic [2:0] OP_FEAT  = 3'd1;
  localparam logic [2:0] OP_DATA  = 3'd2;
  localparam logic [2:0] OP_FIND  = 3'd3;
  localparam logic [2:0] OP_START = 3'd4;
  localparam logic [2:0] OP_NEXT  = 3'd5;

  // status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_SIZE     = 3'd1;
  localparam logic [2:0] ST_FULL     = 3'd2;
  localparam logic [2:0] ST_TYPE     = 3'd3;
  localparam logic [2:0] ST_NOTFOUND = 3'd4;
  localparam logic [2:0] ST_NOWALK   = 3'd5;
  localparam logic [2:0] ST_BUSY     = 3'd6;
  localparam logic [2:0] ST_NODATA   = 3'd7;

  typedef struct packed {
    logic [2:0] operation;
    logic [7:0] option_type;
    logic [7:0] feature_number;
    logic [7:0] data_length;
    logic [7:0] data_byte;
    logic [7:0] max_data;
  } req_t;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] found_type;
    logic [7:0] found_length;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       last;
    logic [8:0] padded_size;
  } rsp_t;

  typedef enum logic [2:0] {
    CL_ADD   = 3'd0,
    CL_FEAT  = 3'd1,
    CL_DATA  = 3'd2,
    CL_FIND  = 3'd3,
    CL_START = 3'd4,
    CL_NEXT  = 3'd5,
    CL_NOP   = 3'd6
  } cls_e;

  typedef struct packed {
    cls_e cls;
    req_t req;
  } cmd_t;

  // queue head handed to the back end
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } qhead_t;

endpackage

FILE: hw/rtl/tlvob_ram.sv
// Generic single write, single read RAM with registered read data.
module tlvob_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/tlvob_front.sv
// Front end: takes requests, classifies them and queues them for the back end.
module tlvob_front
  import tlvob_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   start_i,
  input  req_t   req_i,
  output logic   busy_o,
  output qhead_t head_o,
  input  logic   pop_i
);

  localparam int unsigned PW = $clog2(QUEUE_DEPTH);

  cmd_t        q_mem_q [QUEUE_DEPTH];
  logic [PW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [PW:0]   cnt_q, cnt_d;
  cmd_t        cmd_in;
  logic        push, pop;

  always_comb begin
    cmd_in.req = req_i;
    case (req_i.operation)
      OP_ADD:   cmd_in.cls = CL_ADD;
      OP_FEAT:  cmd_in.cls = CL_FEAT;
      OP_DATA:  cmd_in.cls = CL_DATA;
      OP_FIND:  cmd_in.cls = CL_FIND;
      OP_START: cmd_in.cls = CL_START;
      OP_NEXT:  cmd_in.cls = CL_NEXT;
      default:  cmd_in.cls = CL_NOP;
    endcase
  end

  assign busy_o = (cnt_q == (PW+1)'(QUEUE_DEPTH));
  assign push   = start_i && !busy_o;
  assign pop    = pop_i && (cnt_q != '0);

  always_comb begin
    wr_d  = push ? ((wr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1) : wr_q;
    rd_d  = pop  ? ((rd_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1) : rd_q;
    cnt_d = cnt_q + (PW+1)'(push) - (PW+1)'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem_q[wr_q] <= cmd_in;
    end
  end

  assign head_o.valid = (cnt_q != '0);
  assign head_o.cmd   = q_mem_q[rd_q];

endmodule

FILE: hw/rtl/tlvob_back.sv
// Back end: executes queued requests against the option store.
module tlvob_back
  import tlvob_pkg::*;
#(
  parameter int unsigned BufBytes = BUF_BYTES
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  input  logic [8:0] cfg_data_i,
  input  qhead_t     head_i,
  output logic       pop_o,
  output logic       rsp_valid_o,
  output rsp_t       rsp_o
);

  localparam int unsigned AW = $clog2(BufBytes);
  localparam int unsigned CW = $clog2(BufBytes + 1);
  localparam int unsigned SW = ((CW > 9) ? CW : 9) + 1;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_WLEN  = 6'b000010,
    S_WFEAT = 6'b000100,
    S_TYPE  = 6'b001000,
    S_LEN   = 6'b010000,
    S_DATA  = 6'b100000
  } state_e;

  state_e        state_q, state_d;
  cmd_t          cur_q, cur_d;
  logic [CW-1:0] fill_q, fill_d, wp_q, wp_d, ptr_q, ptr_d;
  logic          walk_q, walk_d, match_q, match_d;
  logic [7:0]    pend_q, pend_d, t_q, t_d, ds_q, ds_d, cnt_q, cnt_d;
  logic [8:0]    cap_q;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [7:0]    wdata, rdata;

  rsp_t          rsp_d, rsp_q;
  logic          rv_d, rv_q;

  logic [SW-1:0] usable, plen, flen, sum_room, nxt;
  logic [7:0]    ds_rd;
  logic [SW-1:0] padded;
  req_t          r;

  tlvob_ram #(.Width(8), .Depth(BufBytes)) u_store (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign r        = head_i.cmd.req;
  assign usable   = (SW'(cap_q) > SW'(BufBytes)) ? SW'(BufBytes) : SW'(cap_q);
  assign plen     = (r.data_length == 8'd0) ? SW'(1) : SW'(r.data_length) + SW'(2);
  assign flen     = SW'(r.data_length) + SW'(3);
  assign ds_rd    = (rdata >= 8'd2) ? rdata - 8'd2 : 8'd0;
  assign nxt      = SW'(ptr_q) + SW'(2) + SW'(ds_rd);

  always_comb begin
    state_d = state_q;
    cur_d   = cur_q;
    fill_d  = fill_q;
    wp_d    = wp_q;
    walk_d  = walk_q;
    pend_d  = pend_q;
    ptr_d   = ptr_q;
    t_d     = t_q;
    ds_d    = ds_q;
    cnt_d   = cnt_q;
    match_d = match_q;
    we      = 1'b0;
    waddr   = fill_q[AW-1:0];
    wdata   = r.option_type;
    raddr   = '0;
    pop_o   = 1'b0;
    rv_d    = 1'b0;
    rsp_d   = '0;
    rsp_d.last = 1'b1;
    sum_room = '0;

    case (state_q)
      S_IDLE: begin
        if (head_i.valid) begin
          pop_o = 1'b1;
          cur_d = head_i.cmd;
          rv_d  = 1'b1;
          rsp_d.status = ST_OK;
          if (head_i.cmd.cls == CL_DATA) begin
            if (pend_q == 8'd0) begin
              rsp_d.status = ST_NODATA;
            end else begin
              we     = 1'b1;
              wdata  = r.data_byte;
              fill_d = fill_q + 1'b1;
              pend_d = pend_q - 1'b1;
            end
          end else if (head_i.cmd.cls == CL_NOP) begin
            rsp_d.status = ST_OK;
          end else if (pend_q != 8'd0) begin
            rsp_d.status = ST_BUSY;
          end else begin
            case (head_i.cmd.cls)
              CL_ADD: begin
                sum_room = SW'(fill_q) + plen;
                if ((r.option_type < SINGLE_LIMIT && r.data_length != 8'd0) ||
                    (r.option_type >= SINGLE_LIMIT && r.data_length == 8'd0) ||
                    plen > SW'(MAX_OPTION_LEN)) begin
                  rsp_d.status = ST_SIZE;
                end else if (sum_room > usable) begin
                  rsp_d.status = ST_FULL;
                end else begin
                  we = 1'b1;
                  if (r.data_length == 8'd0) begin
                    fill_d = fill_q + 1'b1;
                  end else begin
                    rv_d    = 1'b0;
                    state_d = S_WLEN;
                  end
                end
              end
              CL_FEAT: begin
                sum_room = SW'(fill_q) + flen;
                if (r.data_length == 8'd0 || flen > SW'(MAX_OPTION_LEN)) begin
                  rsp_d.status = ST_SIZE;
                end else if (r.option_type < FEAT_FIRST || r.option_type > FEAT_LAST) begin
                  rsp_d.status = ST_TYPE;
                end else if (sum_room > usable) begin
                  rsp_d.status = ST_FULL;
                end else begin
                  we      = 1'b1;
                  rv_d    = 1'b0;
                  state_d = S_WLEN;
                end
              end
              CL_FIND: begin
                if (fill_q == '0) begin
                  rsp_d.status = ST_NOTFOUND;
                end else begin
                  rv_d    = 1'b0;
                  ptr_d   = '0;
                  raddr   = '0;
                  state_d = S_TYPE;
                end
              end
              CL_START: begin
                wp_d   = '0;
                walk_d = 1'b1;
              end
              CL_NEXT: begin
                if (!walk_q) begin
                  rsp_d.status = ST_NOWALK;
                end else if (wp_q >= fill_q) begin
                  rsp_d.status = ST_NOTFOUND;
                end else begin
                  rv_d    = 1'b0;
                  ptr_d   = wp_q;
                  raddr   = wp_q[AW-1:0];
                  state_d = S_TYPE;
                end
              end
              default: rsp_d.status = ST_OK;
            endcase
          end
        end
      end

      S_WLEN: begin
        we    = 1'b1;
        waddr = AW'(fill_q + 1'b1);
        if (cur_q.cls == CL_FEAT) begin
          wdata   = cur_q.req.data_length + 8'd3;
          state_d = S_WFEAT;
        end else begin
          wdata   = cur_q.req.data_length + 8'd2;
          fill_d  = fill_q + CW'(2);
          pend_d  = cur_q.req.data_length;
          rv_d    = 1'b1;
          state_d = S_IDLE;
        end
      end

      S_WFEAT: begin
        we      = 1'b1;
        waddr   = AW'(fill_q + CW'(2));
        wdata   = cur_q.req.feature_number;
        fill_d  = fill_q + CW'(3);
        pend_d  = cur_q.req.data_length;
        rv_d    = 1'b1;
        state_d = S_IDLE;
      end

      S_TYPE: begin
        t_d     = rdata;
        match_d = (cur_q.cls == CL_NEXT) || (rdata == cur_q.req.option_type);
        if (rdata < SINGLE_LIMIT) begin
          if (match_d) begin
            rv_d              = 1'b1;
            rsp_d.found_type  = rdata;
            if (cur_q.cls == CL_NEXT) wp_d = ptr_q + 1'b1;
            state_d = S_IDLE;
          end else if ((ptr_q + 1'b1) >= fill_q) begin
            rv_d         = 1'b1;
            rsp_d.status = ST_NOTFOUND;
            state_d      = S_IDLE;
          end else begin
            ptr_d = ptr_q + 1'b1;
            raddr = AW'(ptr_q + 1'b1);
          end
        end else begin
          raddr   = AW'(ptr_q + 1'b1);
          state_d = S_LEN;
        end
      end

      S_LEN: begin
        ds_d = ds_rd;
        if (!match_q) begin
          if (nxt >= SW'(fill_q)) begin
            rv_d         = 1'b1;
            rsp_d.status = ST_NOTFOUND;
            state_d      = S_IDLE;
          end else begin
            ptr_d   = CW'(nxt);
            raddr   = AW'(nxt);
            state_d = S_TYPE;
          end
        end else if (cur_q.req.max_data < ds_rd) begin
          rv_d               = 1'b1;
          rsp_d.status       = ST_SIZE;
          rsp_d.found_type   = t_q;
          rsp_d.found_length = ds_rd;
          state_d            = S_IDLE;
        end else begin
          if (cur_q.cls == CL_NEXT) wp_d = CW'(nxt);
          if (ds_rd == 8'd0) begin
            rv_d             = 1'b1;
            rsp_d.found_type = t_q;
            state_d          = S_IDLE;
          end else begin
            cnt_d   = '0;
            raddr   = AW'(ptr_q + CW'(2));
            state_d = S_DATA;
          end
        end
      end

      S_DATA: begin
        rv_d               = 1'b1;
        rsp_d.found_type   = t_q;
        rsp_d.found_length = ds_q;
        rsp_d.out_byte     = rdata;
        rsp_d.byte_valid   = 1'b1;
        rsp_d.last         = (cnt_q == ds_q - 1'b1);
        raddr              = AW'(ptr_q + CW'(3) + CW'(cnt_q));
        cnt_d              = cnt_q + 1'b1;
        if (rsp_d.last) state_d = S_IDLE;
      end

      default: state_d = S_IDLE;
    endcase

    padded = (SW'(fill_d) + SW'(3)) & ~SW'(3);
    rsp_d.padded_size = padded[8:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      fill_q  <= '0;
      wp_q    <= '0;
      walk_q  <= 1'b0;
      pend_q  <= '0;
      cap_q   <= 9'd256;
      rv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      wp_q    <= wp_d;
      walk_q  <= walk_d;
      pend_q  <= pend_d;
      rv_q    <= rv_d;
      if (cfg_valid_i) cap_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q   <= cur_d;
    ptr_q   <= ptr_d;
    t_q     <= t_d;
    ds_q    <= ds_d;
    cnt_q   <= cnt_d;
    match_q <= match_d;
    rsp_q   <= rsp_d;
  end

  assign rsp_valid_o = rv_q;
  assign rsp_o       = rsp_q;

  a_fill_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CW'(BufBytes)) else $error("fill count beyond store");
  a_walk_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    wp_q <= fill_q) else $error("walk position beyond fill");
  a_byte_ok : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rv_q && rsp_q.byte_valid |-> rsp_q.status == ST_OK) else $error("data byte with error");
  a_no_pop_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> state_q == S_IDLE) else $error("dequeue while executing");

endmodule

FILE: hw/rtl/tlv_option_list_builder_parser_top.sv
// Top level of the TLV option list builder and parser.
// Flow: an accepted request is written into the front-end queue; the back end pops
//   it in S_IDLE and registers its result; adds with data pass S_WLEN (and S_WFEAT
//   for feature options) first. The queue takes requests while the back end works,
//   until full; find and next read the type, and for longer options the length, of
//   each option visited, then return one data byte per cycle; one store read port.
// Reset: asynchronous, active low; counters, walk and pending count clear, the
//   capacity register returns to 256, store contents stay undefined.
// Results cannot be stalled by the receiver; busy_o holds requests off.
module tlv_option_list_builder_parser_top
  import tlvob_pkg::*;
#(
  parameter int unsigned BufBytes = BUF_BYTES
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // configuration: usable capacity in bytes
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [8:0] cfg_data_i,
  // request channel
  input  logic       start_i,
  input  req_t       req_i,
  output logic       busy_o,
  // result channel
  output logic       rsp_valid_o,
  output rsp_t       rsp_o
);

  qhead_t head;
  logic   pop;

  // capacity writes are always taken
  assign cfg_ready_o = 1'b1;

  // front end: classify and queue requests
  tlvob_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .req_i  (req_i),
    .busy_o (busy_o),
    .head_o (head),
    .pop_i  (pop)
  );

  // back end: store, walk and result sequencing
  tlvob_back #(.BufBytes(BufBytes)) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_data_i (cfg_data_i),
    .head_i     (head),
    .pop_o      (pop),
    .rsp_valid_o(rsp_valid_o),
    .rsp_o      (rsp_o)
  );

endmodule

FILE: bench/tlv_option_list_builder_parser_top_tb.sv
// Testbench for the TLV option list builder and parser: directed table, then random requests.
`timescale 1ns / 1ps

module tlv_option_list_builder_parser_top_tb;
  import tlvob_pkg::*;

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_valid_i;
  logic       cfg_ready_o;
  logic [8:0] cfg_data_i;
  logic       start_i;
  req_t       req_i;
  logic       busy_o;
  logic       rsp_valid_o;
  rsp_t       rsp_o;

  tlv_option_list_builder_parser_top uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .start_i     (start_i),
    .req_i       (req_i),
    .busy_o      (busy_o),
    .rsp_valid_o (rsp_valid_o),
    .rsp_o       (rsp_o)
  );

  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned DRAIN_CYCLES = 40;

  // shadow copy of the block state
  logic [7:0] shadow_store [BUF_BYTES];
  int unsigned fill_cnt;
  int unsigned walk_pos;
  bit          walk_on;
  int unsigned pend_cnt;
  int unsigned cap_bytes;

  rsp_t        expected_rsps [$];
  logic [2:0]  pred_status;
  int unsigned errors;
  int unsigned cycles;
  int unsigned req_count;
  int unsigned rsp_count;
  bit          idle_free;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("tlv_option_list_builder_parser_top regression: fail");
        $finish;
      end
    end
  end

  function automatic rsp_t mk_rsp(logic [2:0] st, logic [7:0] t, logic [7:0] l,
                                  logic [7:0] b, logic v);
    rsp_t r;
    r.status = st;
    r.found_type = t;
    r.found_length = l;
    r.out_byte = b;
    r.byte_valid = v;
    r.last = 1'b0;
    r.padded_size = '0;
    return r;
  endfunction

  function automatic int unsigned opt_data_cnt(int unsigned p);
    int unsigned len;
    len = (p + 1 < BUF_BYTES) ? shadow_store[p + 1] : 0;
    return (len >= 2) ? len - 2 : 0;
  endfunction

  // pushes the results of returning the option at p; gives bytes consumed, 0 on size error
  function automatic int unsigned emit_option(int unsigned p, logic [7:0] maxd,
                                              ref rsp_t res [$]);
    logic [7:0] t;
    int unsigned ds;
    t = shadow_store[p];
    if (t < SINGLE_LIMIT) begin
      res.push_back(mk_rsp(ST_OK, t, 0, 0, 0));
      return 1;
    end
    ds = opt_data_cnt(p);
    if (maxd < ds) begin
      res.push_back(mk_rsp(ST_SIZE, t, ds[7:0], 0, 0));
      return 0;
    end
    if (ds == 0) res.push_back(mk_rsp(ST_OK, t, 0, 0, 0));
    for (int unsigned i = 0; i < ds; i++)
      res.push_back(mk_rsp(ST_OK, t, ds[7:0], shadow_store[(p + 2 + i) % BUF_BYTES], 1));
    return 2 + ds;
  endfunction

  function automatic bit has_room(int unsigned len);
    int unsigned u;
    u = (cap_bytes < BUF_BYTES) ? cap_bytes : BUF_BYTES;
    return fill_cnt + len <= u;
  endfunction

  // computes the results of one request and updates the shadow state
  task automatic predict_request(req_t rq);
    rsp_t res [$];
    logic [2:0] st;
    int unsigned len, w;
    logic [8:0] pad;
    if (rq.operation == OP_DATA) begin
      if (pend_cnt == 0) res.push_back(mk_rsp(ST_NODATA, 0, 0, 0, 0));
      else begin
        shadow_store[fill_cnt] = rq.data_byte;
        fill_cnt++;
        pend_cnt--;
        res.push_back(mk_rsp(ST_OK, 0, 0, 0, 0));
      end
    end else if (rq.operation > OP_NEXT) begin
      res.push_back(mk_rsp(ST_OK, 0, 0, 0, 0));
    end else if (pend_cnt != 0) begin
      res.push_back(mk_rsp(ST_BUSY, 0, 0, 0, 0));
    end else if (rq.operation == OP_ADD) begin
      len = (rq.data_length == 0) ? 1 : rq.data_length + 2;
      if ((rq.option_type < SINGLE_LIMIT && rq.data_length > 0) ||
          (rq.option_type >= SINGLE_LIMIT && rq.data_length == 0) || len > MAX_OPTION_LEN)
        st = ST_SIZE;
      else st = has_room(len) ? ST_OK : ST_FULL;
      if (st == ST_OK) begin
        shadow_store[fill_cnt] = rq.option_type;
        fill_cnt++;
        if (rq.data_length > 0) begin
          shadow_store[fill_cnt] = len[7:0];
          fill_cnt++;
          pend_cnt = rq.data_length;
        end
      end
      res.push_back(mk_rsp(st, 0, 0, 0, 0));
    end else if (rq.operation == OP_FEAT) begin
      len = rq.data_length + 3;
      if (rq.data_length == 0 || len > MAX_OPTION_LEN) st = ST_SIZE;
      else if (rq.option_type < FEAT_FIRST || rq.option_type > FEAT_LAST) st = ST_TYPE;
      else st = has_room(len) ? ST_OK : ST_FULL;
      if (st == ST_OK) begin
        shadow_store[fill_cnt] = rq.option_type;
        shadow_store[fill_cnt + 1] = len[7:0];
        shadow_store[fill_cnt + 2] = rq.feature_number;
        fill_cnt += 3;
        pend_cnt = rq.data_length;
      end
      res.push_back(mk_rsp(st, 0, 0, 0, 0));
    end else if (rq.operation == OP_FIND) begin
      w = 0;
      while (w < fill_cnt) begin
        if (shadow_store[w] == rq.option_type) begin
          void'(emit_option(w, rq.max_data, res));
          break;
        end
        w += (shadow_store[w] < SINGLE_LIMIT) ? 1 : 2 + opt_data_cnt(w);
      end
      if (res.size() == 0) res.push_back(mk_rsp(ST_NOTFOUND, 0, 0, 0, 0));
    end else if (rq.operation == OP_START) begin
      walk_pos = 0;
      walk_on = 1'b1;
      res.push_back(mk_rsp(ST_OK, 0, 0, 0, 0));
    end else begin
      if (!walk_on) res.push_back(mk_rsp(ST_NOWALK, 0, 0, 0, 0));
      else if (walk_pos >= fill_cnt) res.push_back(mk_rsp(ST_NOTFOUND, 0, 0, 0, 0));
      else walk_pos += emit_option(walk_pos, rq.max_data, res);
    end
    pad = 9'((fill_cnt + 3) & ~32'd3);
    pred_status = res[0].status;
    foreach (res[k]) begin
      res[k].padded_size = pad;
      res[k].last = (k == res.size() - 1);
      expected_rsps.push_back(res[k]);
    end
  endtask

  // result checker: the block cannot be held off, so sample every strobe
  always @(posedge clk_i) begin
    rsp_t e;
    if (rst_ni && rsp_valid_o) begin
      rsp_count++;
      if (expected_rsps.size() == 0) begin
        $error("unexpected result %p", rsp_o);
        errors++;
      end else begin
        e = expected_rsps.pop_front();
        if (rsp_o.status !== e.status) begin
          $error("status exp %0d got %0d", e.status, rsp_o.status); errors++;
        end
        if (rsp_o.found_type !== e.found_type) begin
          $error("found_type exp %0d got %0d", e.found_type, rsp_o.found_type); errors++;
        end
        if (rsp_o.found_length !== e.found_length) begin
          $error("found_length exp %0d got %0d", e.found_length, rsp_o.found_length);
          errors++;
        end
        if (rsp_o.out_byte !== e.out_byte) begin
          $error("out_byte exp %0d got %0d", e.out_byte, rsp_o.out_byte); errors++;
        end
        if (rsp_o.byte_valid !== e.byte_valid) begin
          $error("byte_valid exp %0d got %0d", e.byte_valid, rsp_o.byte_valid); errors++;
        end
        if (rsp_o.last !== e.last) begin
          $error("last exp %0d got %0d", e.last, rsp_o.last); errors++;
        end
        if (rsp_o.padded_size !== e.padded_size) begin
          $error("padded_size exp %0d got %0d", e.padded_size, rsp_o.padded_size); errors++;
        end
      end
    end
  end

  // issue one request, with a random gap first unless in the no-idle stretch;
  // start_i stays high after acceptance so the next request can follow directly
  task automatic send_request(req_t rq);
    if (!idle_free && $urandom_range(99) < 11) begin
      start_i <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < 11) @(posedge clk_i);
    end
    start_i <= 1'b1;
    req_i   <= rq;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    predict_request(rq);
    req_count++;
  endtask

  // wait until the block has drained, then write the capacity register
  task automatic write_capacity(logic [8:0] val);
    start_i <= 1'b0;
    while (expected_rsps.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    cap_bytes = val;
  endtask

  function automatic req_t mk_req(logic [2:0] op, logic [7:0] t, logic [7:0] f,
                                  logic [7:0] dl, logic [7:0] db, logic [7:0] md);
    req_t r;
    r.operation = op;
    r.option_type = t;
    r.feature_number = f;
    r.data_length = dl;
    r.data_byte = db;
    r.max_data = md;
    return r;
  endfunction

  function automatic req_t rand_req();
    logic [63:0] raw;
    req_t r;
    raw = {$urandom(), $urandom()};
    r = raw[$bits(req_t)-1:0];
    return r;
  endfunction

  // directed table; chk marks rows whose status is typed in, others rely on the predictor
  typedef struct {
    req_t       rq;
    bit         chk;
    logic [2:0] st;
  } dir_row_t;

  dir_row_t dir_rows [$];

  task automatic add_row(req_t rq, bit chk, logic [2:0] st);
    dir_row_t d;
    d.rq = rq;
    d.chk = chk;
    d.st = st;
    dir_rows.push_back(d);
  endtask

  // a well-formed option: header plus all its data bytes
  task automatic send_option();
    logic [7:0] t, dl;
    int unsigned kind;
    kind = $urandom_range(9);
    if (kind < 3) begin
      send_request(mk_req(OP_ADD, 8'($urandom_range(31)), 8'($urandom()), 0,
                          8'($urandom()), 8'($urandom())));
      return;
    end
    dl = (kind == 9) ? 8'($urandom_range(61)) : 8'($urandom_range(1, 6));
    if (kind < 6) begin
      t  = 8'($urandom_range(FEAT_FIRST, FEAT_LAST));
      if (dl == 0 || dl > 61) dl = 1;
      send_request(mk_req(OP_FEAT, t, 8'($urandom()), dl, 0, 8'($urandom())));
    end else begin
      t = 8'($urandom_range(32, 255));
      if (dl == 0) dl = 2;
      send_request(mk_req(OP_ADD, t, 8'($urandom()), dl, 0, 8'($urandom())));
    end
    while (pend_cnt != 0)
      send_request(mk_req(OP_DATA, 8'($urandom()), 8'($urandom()), 8'($urandom()),
                          8'($urandom()), 8'($urandom())));
  endtask

  initial begin
    logic [8:0] caps [5];
    errors = 0;
    req_count = 0;
    rsp_count = 0;
    idle_free = 1'b0;
    fill_cnt = 0;
    walk_pos = 0;
    walk_on = 1'b0;
    pend_cnt = 0;
    cap_bytes = 256;
    pred_status = ST_OK;
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_data_i = '0;
    start_i = 1'b0;
    req_i = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    add_row(mk_req(OP_NEXT, 0, 0, 0, 0, 0), 1, ST_NOWALK);
    add_row(mk_req(OP_DATA, 0, 0, 0, 8'hFF, 0), 1, ST_NODATA);
    add_row(mk_req(OP_FIND, 8'hFF, 0, 0, 0, 8'hFF), 1, ST_NOTFOUND);
    add_row(mk_req(OP_ADD, 8'd5, 0, 8'd1, 0, 0), 1, ST_SIZE);
    add_row(mk_req(OP_ADD, 8'hFF, 0, 8'd0, 0, 0), 1, ST_SIZE);
    add_row(mk_req(OP_ADD, 8'hFF, 0, 8'd63, 0, 0), 1, ST_SIZE);
    add_row(mk_req(OP_FEAT, 8'd36, 0, 8'd1, 0, 0), 1, ST_TYPE);
    add_row(mk_req(OP_FEAT, 8'd32, 0, 8'd0, 0, 0), 1, ST_SIZE);
    add_row(mk_req(OP_FEAT, 8'd33, 0, 8'd62, 0, 0), 1, ST_SIZE);
    add_row(mk_req(OP_ADD, 8'd0, 8'hFF, 0, 0, 0), 1, ST_OK);
    add_row(mk_req(OP_ADD, 8'hFF, 0, 8'd2, 0, 0), 1, ST_OK);
    add_row(mk_req(OP_FIND, 8'hFF, 0, 0, 0, 0), 1, ST_BUSY);
    add_row(mk_req(OP_DATA, 0, 0, 0, 8'h00, 0), 1, ST_OK);
    add_row(mk_req(OP_DATA, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF), 1, ST_OK);
    add_row(mk_req(OP_FEAT, 8'd35, 8'hAA, 8'd1, 0, 0), 1, ST_OK);
    add_row(mk_req(OP_DATA, 0, 0, 0, 8'h55, 0), 1, ST_OK);
    add_row(mk_req(3'd6, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF), 1, ST_OK);
    add_row(mk_req(3'd7, 0, 0, 0, 0, 0), 1, ST_OK);
    add_row(mk_req(OP_FIND, 8'hFF, 0, 0, 0, 8'd1), 1, ST_SIZE);
    add_row(mk_req(OP_FIND, 8'hFF, 0, 0, 0, 8'hFF), 0, ST_OK);
    add_row(mk_req(OP_START, 0, 0, 0, 0, 0), 1, ST_OK);
    add_row(mk_req(OP_NEXT, 0, 0, 0, 0, 0), 0, ST_OK);
    add_row(mk_req(OP_NEXT, 0, 0, 0, 0, 0), 1, ST_SIZE);
    add_row(mk_req(OP_NEXT, 0, 0, 0, 0, 8'd2), 0, ST_OK);
    add_row(mk_req(OP_NEXT, 0, 0, 0, 0, 8'hFF), 0, ST_OK);
    add_row(mk_req(OP_NEXT, 0, 0, 0, 0, 8'hFF), 1, ST_NOTFOUND);

    foreach (dir_rows[i]) begin
      send_request(dir_rows[i].rq);
      if (dir_rows[i].chk && pred_status !== dir_rows[i].st) begin
        $error("status exp %0d got %0d", dir_rows[i].st, pred_status);
        errors++;
      end
    end

    // capacity extremes: zero, tight, odd, beyond depth, full
    caps = '{9'd0, 9'd7, 9'd37, 9'd511, 9'd256};
    foreach (caps[c]) begin
      write_capacity(caps[c]);
      // restart the buffer from empty cannot be done without reset, so fill further
      for (int unsigned n = 0; n < 30; n++) begin
        idle_free = (c == 2);
        case ($urandom_range(9))
          0: send_request(rand_req());
          1: send_request(mk_req(OP_START, 8'($urandom()), 8'($urandom()), 8'($urandom()),
                                 8'($urandom()), 8'($urandom())));
          2, 3: send_request(mk_req(OP_NEXT, 8'($urandom()), 0, 0, 0,
                                    ($urandom_range(3) == 0) ? 8'($urandom()) : 8'hFF));
          4: send_request(mk_req(OP_FIND,
                                 (fill_cnt > 0) ? shadow_store[$urandom_range(fill_cnt - 1)]
                                                : 8'($urandom()),
                                 0, 0, 0, 8'($urandom())));
          default: send_option();
        endcase
      end
    end
    idle_free = 1'b0;
    start_i <= 1'b0;

    while (expected_rsps.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("covered %0d requests, %0d results, five capacity settings", req_count,
             rsp_count);
    $display("final fill %0d bytes", fill_cnt);
    if (errors == 0 && expected_rsps.size() == 0)
      $display("tlv_option_list_builder_parser_top regression: pass");
    else
      $display("tlv_option_list_builder_parser_top regression: fail");
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/tlvob_pkg.sv
hw/rtl/tlvob_ram.sv
hw/rtl/tlvob_front.sv
hw/rtl/tlvob_back.sv
hw/rtl/tlv_option_list_builder_parser_top.sv
bench/tlv_option_list_builder_parser_top_tb.sv
